// ----- design/nine_bit_frame_receiver_crc16_assert.svh -----
// Assertion macros shared by the frame receiver modules.
`ifndef NINE_BIT_FRAME_RECEIVER_CRC16_ASSERT_SVH
`define NINE_BIT_FRAME_RECEIVER_CRC16_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NBFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NBFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/nbfr_pkg.sv -----
// Types, constants and the CRC byte update for the frame receiver.
package nbfr_pkg;

    localparam int CHAR_W = 9;
    localparam int WORD_W = 16;
    localparam int WIDX_W = 6;
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic STATUS_GOOD  = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    // One classified frame byte handed from the front to the back.
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } t_qent;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [2:0] {
        S_RUN   = 3'b001,
        S_FETCH = 3'b010,
        S_LOAD  = 3'b100
    } t_bstate;

    // Reflected CRC-16 update over one byte, LSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] v;
        v = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (v[0]) begin
                v = (v >> 1) ^ CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

endpackage

// ----- design/nbfr_ifs.sv -----
// Valid/ready channel interfaces for the character input and the word output.
interface nbfr_in_if import nbfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_value;
    logic              line_error;

    modport source(output valid, char_value, line_error, input ready);
    modport sink(input valid, char_value, line_error, output ready);
endinterface

interface nbfr_out_if import nbfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              status;
    logic [WORD_W-1:0] payload_word;
    logic [WIDX_W-1:0] word_index;
    logic              last;

    modport source(output valid, status, payload_word, word_index, last, input ready);
    modport sink(input valid, status, payload_word, word_index, last, output ready);
endinterface

// ----- design/nine_bit_frame_receiver_crc16.sv -----
// Characters enter the 4-entry byte queue at the accepting edge; the back end takes a byte a cycle
// while its output slot is free and no good frame's words are being sent. An error result is
// registered as the last frame byte is taken; each good word needs a store read, then a load.
// Input takes one character a cycle until the queue fills during a word burst or output stall.
// Reset is synchronous, active low: no frame open, CRC at 0xFFFF, queue and output empty.
// The payload store is not cleared; every entry is written before its frame can be read.
module nine_bit_frame_receiver_crc16 import nbfr_pkg::*; #(
    parameter int PAYLOAD_WORDS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nbfr_in_if.sink     i_in,
    nbfr_out_if.source  o_out
);

    t_qent  q_entry;
    t_qent  q_head;
    t_qstat q_stat;
    logic   q_push;
    logic   q_pop;

    nbfr_front #(
        .PAYLOAD_WORDS(PAYLOAD_WORDS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_qstat (q_stat),
        .o_push  (q_push),
        .o_entry (q_entry)
    );

    nbfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_entry),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_qstat (q_stat)
    );

    nbfr_back #(
        .PAYLOAD_WORDS(PAYLOAD_WORDS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .i_qstat (q_stat),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

// ----- design/nbfr_front.sv -----
// Front end: drops bad characters, tracks frame position and queues frame bytes.
module nbfr_front import nbfr_pkg::*; #(
    parameter int PAYLOAD_WORDS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nbfr_in_if.sink     i_in,
    input  t_qstat      i_qstat,
    output logic        o_push,
    output t_qent       o_entry
);

    localparam int FRAME_BYTES = 2 * PAYLOAD_WORDS + 2;
    localparam int PCW         = $clog2(FRAME_BYTES);
    localparam logic [PCW-1:0] LAST_POS = PCW'(FRAME_BYTES - 1);

    logic [PCW-1:0] r_cnt;
    logic [PCW-1:0] n_cnt;
    logic           accept;

    assign i_in.ready = !i_qstat.full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_cnt         = r_cnt;
        o_push        = 1'b0;
        o_entry.data  = i_in.char_value[7:0];
        o_entry.first = 1'b0;
        o_entry.last  = 1'b0;
        if (accept && !i_in.line_error) begin
            priority if (i_in.char_value[8]) begin
                // A start byte always opens a fresh frame, abandoning any open one.
                o_push        = 1'b1;
                o_entry.first = 1'b1;
                n_cnt         = PCW'(1);
            end else if (r_cnt != '0) begin
                o_push       = 1'b1;
                o_entry.last = (r_cnt == LAST_POS);
                n_cnt        = (r_cnt == LAST_POS) ? '0 : r_cnt + PCW'(1);
            end else begin
                // An unmarked byte with no frame open is ignored.
                o_push = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- design/nbfr_queue.sv -----
// Short byte queue between the front end and the back end.
`include "nine_bit_frame_receiver_crc16_assert.svh"
module nbfr_queue import nbfr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_qent  i_entry,
    input  logic   i_pop,
    output t_qent  o_head,
    output t_qstat o_qstat
);

    t_qent          r_slot [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QAW:0]   r_count;
    logic [QAW:0]   n_count;

    assign o_head        = r_slot[r_rptr];
    assign o_qstat.full  = (r_count == (QAW + 1)'(QDEPTH));
    assign o_qstat.empty = (r_count == '0);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (QAW + 1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (QAW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QAW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QAW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_entry;
        end
    end

    `NBFR_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n,
        i_push, !o_qstat.full || i_pop, "queue overflow")
    `NBFR_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n,
        i_pop, !o_qstat.empty, "queue underflow")
    `NBFR_ASSERT_IMPL(a_count_range, i_clk, i_rst_n,
        1'b1, r_count <= (QAW + 1)'(QDEPTH), "queue count out of range")

endmodule

// ----- design/nbfr_back.sv -----
// Back end: CRC update, payload store and result word sequencing.
`include "nine_bit_frame_receiver_crc16_assert.svh"
module nbfr_back import nbfr_pkg::*; #(
    parameter int PAYLOAD_WORDS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_qent       i_head,
    input  t_qstat      i_qstat,
    output logic        o_pop,
    nbfr_out_if.source  o_out
);

    localparam int PAYLOAD_BYTES = 2 * PAYLOAD_WORDS;
    localparam int FRAME_BYTES   = PAYLOAD_BYTES + 2;
    localparam int PCW           = $clog2(FRAME_BYTES);
    localparam int WA            = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
    localparam logic [PCW-1:0]    PB       = PCW'(PAYLOAD_BYTES);
    localparam logic [WIDX_W-1:0] LAST_IDX = WIDX_W'(PAYLOAD_WORDS - 1);

    t_bstate           r_state, n_state;
    logic [PCW-1:0]    r_pos, n_pos;
    logic [15:0]       r_crc, n_crc;
    logic [7:0]        r_low, n_low;
    logic [WIDX_W-1:0] r_idx, n_idx;
    logic              r_ov, n_ov;
    logic              r_status, n_status;
    logic [WORD_W-1:0] r_word, n_word;
    logic [WIDX_W-1:0] r_widx, n_widx;
    logic              r_last, n_last;
    logic [WORD_W-1:0] r_mem [PAYLOAD_WORDS];
    logic [WORD_W-1:0] r_rdata;

    logic              slot_free;
    logic [PCW-1:0]    pos;
    logic [15:0]       crc_new;
    logic              mem_we;
    logic [WA-1:0]     mem_wa;
    logic [WORD_W-1:0] mem_wd;
    logic              rd_en;

    assign slot_free = !r_ov || o_out.ready;
    assign pos       = i_head.first ? '0 : r_pos;
    assign crc_new   = crc16_byte(i_head.first ? CRC_INIT : r_crc, i_head.data);
    assign mem_wa    = pos[WA:1];
    assign mem_wd    = {i_head.data, r_low};

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_crc    = r_crc;
        n_low    = r_low;
        n_idx    = r_idx;
        n_ov     = r_ov;
        n_status = r_status;
        n_word   = r_word;
        n_widx   = r_widx;
        n_last   = r_last;
        o_pop    = 1'b0;
        mem_we   = 1'b0;
        rd_en    = 1'b0;
        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            S_RUN: begin
                // Bytes are taken only with the output slot free, so an error
                // result can be posted in the same cycle.
                if (!i_qstat.empty && slot_free) begin
                    o_pop = 1'b1;
                    n_pos = pos + PCW'(1);
                    n_crc = crc_new;
                    if (pos < PB) begin
                        if (!pos[0]) begin
                            n_low = i_head.data;
                        end else begin
                            mem_we = 1'b1;
                        end
                    end
                    if (i_head.last) begin
                        if (crc_new != 16'h0000) begin
                            n_ov     = 1'b1;
                            n_status = STATUS_ERROR;
                            n_word   = '0;
                            n_widx   = '0;
                            n_last   = 1'b1;
                        end else begin
                            n_idx   = '0;
                            n_state = S_FETCH;
                        end
                    end
                end
            end
            S_FETCH: begin
                rd_en   = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (slot_free) begin
                    n_ov     = 1'b1;
                    n_status = STATUS_GOOD;
                    n_word   = r_rdata;
                    n_widx   = r_idx;
                    n_last   = (r_idx == LAST_IDX);
                    if (r_idx == LAST_IDX) begin
                        n_state = S_RUN;
                    end else begin
                        n_idx   = r_idx + WIDX_W'(1);
                        n_state = S_FETCH;
                    end
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_pos   <= '0;
            r_crc   <= CRC_INIT;
            r_idx   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_idx   <= n_idx;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_low    <= n_low;
        r_status <= n_status;
        r_word   <= n_word;
        r_widx   <= n_widx;
        r_last   <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_idx[WA-1:0]];
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.status       = r_status;
    assign o_out.payload_word = r_word;
    assign o_out.word_index   = r_widx;
    assign o_out.last         = r_last;

    `NBFR_ASSERT_IMPL(a_last_word_index, i_clk, i_rst_n,
        r_ov && r_last && (r_status == STATUS_GOOD), r_widx == LAST_IDX,
        "last good word has wrong index")
    `NBFR_ASSERT_IMPL(a_error_shape, i_clk, i_rst_n,
        r_ov && (r_status == STATUS_ERROR), (r_word == '0) && (r_widx == '0) && r_last,
        "error result is malformed")
    `NBFR_ASSERT_NEXT(a_fetch_then_load, i_clk, i_rst_n,
        r_state == S_FETCH, r_state == S_LOAD, "word read not followed by load")

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the nine-bit CRC-16 frame receiver.
`timescale 1ns / 1ps

module testbench;
    import nbfr_pkg::*;

    localparam int PAYLOAD_WORDS = 10;
    localparam int PAYLOAD_BYTES = 2 * PAYLOAD_WORDS;
    localparam int FRAME_BYTES   = PAYLOAD_BYTES + 2;
    localparam int ITEM_TARGET   = 170;
    localparam int IDLE_LIMIT    = 2000;

    typedef struct {
        logic              status;
        logic [WORD_W-1:0] word;
        logic [WIDX_W-1:0] widx;
        logic              last;
    } frame_result_t;

    // Tracks the receiver's frame state and holds the words it must produce.
    class crc_frame_tracker;
        logic [7:0]    held_bytes [PAYLOAD_BYTES];
        int unsigned   open_count;
        logic [15:0]   crc;
        frame_result_t pending[$];
        int            mismatches;
        int            words_seen;
        int            good_frames;
        int            bad_frames;
        int            dropped;
        int            chars_taken;

        function new();
            open_count  = 0;
            crc         = CRC_INIT;
            mismatches  = 0;
            words_seen  = 0;
            good_frames = 0;
            bad_frames  = 0;
            dropped     = 0;
            chars_taken = 0;
            foreach (held_bytes[k]) held_bytes[k] = 8'h00;
        endfunction

        function logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
            logic [15:0] v;
            v = c ^ {8'h00, b};
            repeat (8) begin
                v = v[0] ? ((v >> 1) ^ 16'hA001) : (v >> 1);
            end
            return v;
        endfunction

        function void add_byte(logic [7:0] b);
            if (open_count < PAYLOAD_BYTES) held_bytes[open_count] = b;
            crc = crc_update(crc, b);
            open_count++;
        endfunction

        function void take_char(logic [CHAR_W-1:0] ch, logic err);
            frame_result_t r;
            chars_taken++;
            if (err) begin
                dropped++;
                return;
            end
            if (ch[8]) begin
                open_count = 0;
                crc        = CRC_INIT;
                add_byte(ch[7:0]);
            end else if (open_count > 0) begin
                add_byte(ch[7:0]);
            end else begin
                return;
            end
            if (open_count < FRAME_BYTES) return;
            if (crc != 16'h0000) begin
                r.status = STATUS_ERROR;
                r.word   = '0;
                r.widx   = '0;
                r.last   = 1'b1;
                pending.push_back(r);
                bad_frames++;
            end else begin
                for (int k = 0; k < PAYLOAD_WORDS; k++) begin
                    r.status = STATUS_GOOD;
                    r.word   = {held_bytes[2*k+1], held_bytes[2*k]};
                    r.widx   = k[WIDX_W-1:0];
                    r.last   = (k == PAYLOAD_WORDS - 1);
                    pending.push_back(r);
                end
                good_frames++;
            end
            open_count = 0;
            crc        = CRC_INIT;
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("ERROR at %0t: %s", $realtime, msg);
        endtask

        task match_word(frame_result_t got);
            frame_result_t want;
            words_seen++;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected word st=%0b w=%h i=%0d l=%0b",
                                          got.status, got.word, got.widx, got.last));
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.word !== want.word ||
                got.widx !== want.widx || got.last !== want.last) begin
                report_mismatch($sformatf(
                    "got st=%0b w=%h i=%0d l=%0b, want st=%0b w=%h i=%0d l=%0b",
                    got.status, got.word, got.widx, got.last,
                    want.status, want.word, want.widx, want.last));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    nbfr_in_if  in_if ();
    nbfr_out_if out_if ();

    nine_bit_frame_receiver_crc16 #(
        .PAYLOAD_WORDS(PAYLOAD_WORDS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    crc_frame_tracker tracker = new();

    int burst_left;
    int items_sent;
    int idle_cycles;
    int stall_mode;
    int stall_cycle;

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.char_value   = '0;
        in_if.line_error   = 1'b0;
        out_if.ready       = 1'b0;
        burst_left         = 0;
        items_sent         = 0;
        idle_cycles        = 0;
        stall_mode         = 0;
        stall_cycle        = 0;
    end

    always #5 i_clk = ~i_clk;

    // Both channels are observed at the rising edge only.
    always @(posedge i_clk) begin
        frame_result_t got;
        logic          moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                tracker.take_char(in_if.char_value, in_if.line_error);
                moved = 1'b1;
            end
            if (out_if.valid && out_if.ready) begin
                got.status = out_if.status;
                got.word   = out_if.payload_word;
                got.widx   = out_if.word_index;
                got.last   = out_if.last;
                tracker.match_word(got);
                moved = 1'b1;
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    // The word sink cycles through steady, periodic, random and long-stall patterns.
    always @(negedge i_clk) begin
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 97 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: begin
                out_if.ready <= 1'b1;
            end
            1: begin
                out_if.ready <= (stall_cycle % 3 == 0);
            end
            2: begin
                out_if.ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                out_if.ready <= (stall_cycle % 24 >= 20);
            end
        endcase
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Presents one character; returns at the falling edge after it is accepted.
    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic err);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? 20 : $urandom_range(1, 6);
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 16);
        end
        in_if.valid      = 1'b1;
        in_if.char_value = ch;
        in_if.line_error = err;
        do @(posedge i_clk); while (!in_if.ready);
        burst_left--;
        items_sent++;
        @(negedge i_clk);
    endtask

    // Holds the sender off until every expected word has drained.
    task automatic drain_words();
        in_if.valid = 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        burst_left = $urandom_range(1, 16);
    endtask

    // Sends the first send_len bytes of a frame, optionally with one bit flipped and with
    // line-error characters mixed in at the given rate in percent.
    task automatic send_frame(input logic [7:0] pay [PAYLOAD_BYTES], input bit corrupt,
                              input int send_len, input int err_pct);
        logic [7:0]  fb [FRAME_BYTES];
        logic [15:0] c;
        int          pos;
        c = CRC_INIT;
        for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            fb[k] = pay[k];
            c = tracker.crc_update(c, pay[k]);
        end
        // Low CRC byte first, so the residue over the whole frame is zero.
        fb[PAYLOAD_BYTES]     = c[7:0];
        fb[PAYLOAD_BYTES + 1] = c[15:8];
        if (corrupt) begin
            pos = $urandom_range(0, FRAME_BYTES - 1);
            fb[pos][$urandom_range(0, 7)] ^= 1'b1;
        end
        for (int k = 0; k < send_len; k++) begin
            if ($urandom_range(1, 100) <= err_pct) send_char(9'($urandom_range(0, 511)), 1'b1);
            send_char({(k == 0), fb[k]}, 1'b0);
        end
    endtask

    initial begin
        logic [7:0] pay [PAYLOAD_BYTES];
        int         kind;
        int         pmode;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Unmarked byte with no frame open, then a marked character with a line error.
        send_char(9'h0FF, 1'b0);
        send_char(9'h1FF, 1'b1);
        // A frame that is abandoned when the next start byte arrives.
        send_char(9'h100, 1'b0);
        send_char(9'h0AA, 1'b0);
        for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            pay[k] = (k < 4) ? ((k % 2) ? 8'h00 : 8'hFF) : 8'(k * 8'h3B);
        end
        for (int k = 0; k < FRAME_BYTES; k++) begin
            if (k == 5) send_char(9'h1FF, 1'b1);
        end
        send_frame(pay, 1'b0, FRAME_BYTES, 0);
        drain_words();

        while (items_sent < ITEM_TARGET) begin
            pmode = $urandom_range(0, 3);
            for (int k = 0; k < PAYLOAD_BYTES; k++) begin
                case (pmode)
                    0:       pay[k] = (k % 2) ? 8'hFF : 8'h00;
                    1:       pay[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    default: pay[k] = 8'($urandom_range(0, 255));
                endcase
            end
            kind = $urandom_range(0, 19);
            if (kind < 12) begin
                send_frame(pay, 1'b0, FRAME_BYTES, 8);
            end else if (kind < 15) begin
                send_frame(pay, 1'b1, FRAME_BYTES, 8);
            end else if (kind < 17) begin
                send_frame(pay, 1'b0, $urandom_range(1, FRAME_BYTES - 1), 8);
            end else begin
                repeat ($urandom_range(1, 4)) send_char(9'($urandom_range(0, 511)),
                                                        1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 3) == 0) drain_words();
        end
        in_if.valid = 1'b0;

        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (tracker.pending.size() != 0) begin
            tracker.report_mismatch($sformatf("%0d words never arrived",
                                              tracker.pending.size()));
        end

        $display("Sent %0d characters (%0d dropped on line error).",
                 tracker.chars_taken, tracker.dropped);
        $display("Checked %0d words from %0d good and %0d CRC-failed frames.",
                 tracker.words_seen, tracker.good_frames, tracker.bad_frames);
        if (tracker.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
